>>> hw/rtl/imm_pkg.sv
// Shared codes, widths and types for the integer matrix multiplier.
package imm_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 35;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_MULTIPLY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

    // Tag that travels with each partial product through the pipeline.
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;
        logic             last_k;
        logic             last_elem;
    } imm_tag_t;

    function automatic int addr_w(input int depth);
        addr_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Out-of-range sizes saturate: zero becomes one, anything above the maximum
    // becomes the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > max_dim)
        begin
            r = max_dim;
        end
        clamp_dim = r;
    endfunction

endpackage

>>> hw/rtl/imm_channels.sv
// Valid/ready channel interfaces for commands and product results.
interface imm_cmd_if;
    import imm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output row, output col, output value,
                    input ready);
    modport sink (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

interface imm_res_if;
    import imm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [SUM_W-1:0] product_sum;
    logic                    last;

    modport source (output valid, output out_row, output out_col, output product_sum,
                    output last, input ready);
    modport sink (input valid, input out_row, input out_col, input product_sum,
                  input last, output ready);
endinterface

>>> hw/rtl/imm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module imm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [imm_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [imm_pkg::addr_w(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                    rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> hw/rtl/integer_matrix_multiply.sv
// Integer matrix multiplier: two element stores in RAM and a multiply-accumulate pipeline.
// Loads take one beat per cycle while the command channel is ready. A multiply holds the
// command channel until the whole product is walked, one RAM read pair per cycle unless
// stalled, and yields one result per output element. Result backpressure stalls the
// whole pipeline. After reset a clearing pass zeroes all MAX_DIM*MAX_DIM entries of both
// stores with the command channel not ready; configuration writes are taken throughout.
module integer_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    imm_cmd_if.sink                           cmd,
    imm_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]         cfg_data
);
    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = addr_w(DEPTH);
    localparam int IW    = addr_w(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0] a_rows_reg, inner_dim_reg, b_cols_reg;
    logic             clear_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic             busy_reg;
    logic [IW-1:0]    i_reg, j_reg, k_reg;
    logic             s1_valid_reg, s2_valid_reg;
    imm_tag_t         s1_tag_reg, s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;

    logic             cmd_fire, adv, issue;
    logic             k_last, j_last, i_last;
    logic             left_ok, right_ok;
    logic [AW-1:0]    load_addr;
    logic             l_we, r_we;
    logic [AW-1:0]    l_waddr, r_waddr, l_raddr, r_raddr;
    logic [VAL_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SUM_W-1:0]  acc_sum;
    imm_tag_t         issue_tag;

    assign cmd.ready = !busy_reg && !clear_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign adv       = !out_valid_reg || res.ready;
    assign issue     = busy_reg && adv;

    assign k_last = (DIM_W'(k_reg) + DIM_W'(1)) == inner_dim_reg;
    assign j_last = (DIM_W'(j_reg) + DIM_W'(1)) == b_cols_reg;
    assign i_last = (DIM_W'(i_reg) + DIM_W'(1)) == a_rows_reg;

    assign left_ok  = (cmd.op == OP_LOAD_LEFT) && (DIM_W'(cmd.row) < a_rows_reg)
                      && (DIM_W'(cmd.col) < inner_dim_reg);
    assign right_ok = (cmd.op == OP_LOAD_RIGHT) && (DIM_W'(cmd.row) < inner_dim_reg)
                      && (DIM_W'(cmd.col) < b_cols_reg);
    assign load_addr = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));

    // Write port: the clearing pass owns it after reset, loads afterwards.
    // Loads happen only while not busy; reads are enabled whenever the pipeline advances.
    always_comb
    begin
        if (clear_reg)
        begin
            l_we    = 1'b1;
            r_we    = 1'b1;
            l_waddr = clr_addr_reg;
            r_waddr = clr_addr_reg;
            l_wdata = '0;
            r_wdata = '0;
        end
        else
        begin
            l_we    = cmd_fire && left_ok;
            r_we    = cmd_fire && right_ok;
            l_waddr = load_addr;
            r_waddr = load_addr;
            l_wdata = cmd.value;
            r_wdata = cmd.value;
        end
    end

    assign l_raddr = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign r_raddr = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    imm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (adv),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    imm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (adv),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    always_comb
    begin
        issue_tag.row       = IDX_W'(i_reg);
        issue_tag.col       = IDX_W'(j_reg);
        issue_tag.first     = (k_reg == '0);
        issue_tag.last_k    = k_last;
        issue_tag.last_elem = k_last && j_last && i_last;
    end

    assign prod_next = $signed(l_rdata) * $signed(r_rdata);
    assign acc_sum   = (s2_tag_reg.first ? SUM_W'(0) : acc_reg) + SUM_W'(prod_reg);

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg    <= DIM_MAX;
            inner_dim_reg <= DIM_MAX;
            b_cols_reg    <= DIM_MAX;
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            busy_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_A_ROWS:    a_rows_reg    <= clamp_dim(cfg_data, DIM_MAX);
                    CFG_INNER_DIM: inner_dim_reg <= clamp_dim(cfg_data, DIM_MAX);
                    CFG_B_COLS:    b_cols_reg    <= clamp_dim(cfg_data, DIM_MAX);
                    default:       ;
                endcase
            end

            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end

            if (cmd_fire && cmd.op == OP_MULTIPLY)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                j_reg    <= '0;
                k_reg    <= '0;
            end
            else if (issue)
            begin
                if (!k_last)
                begin
                    k_reg <= k_reg + IW'(1);
                end
                else
                begin
                    k_reg <= '0;
                    if (!j_last)
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                    else
                    begin
                        j_reg <= '0;
                        if (!i_last)
                        begin
                            i_reg <= i_reg + IW'(1);
                        end
                        else
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
            end

            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg && s2_tag_reg.last_k;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= prod_next;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_sum;
            end
            if (s2_valid_reg && s2_tag_reg.last_k)
            begin
                out_row_reg  <= s2_tag_reg.row;
                out_col_reg  <= s2_tag_reg.col;
                out_sum_reg  <= acc_sum;
                out_last_reg <= s2_tag_reg.last_elem;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_row     = out_row_reg;
    assign res.out_col     = out_col_reg;
    assign res.product_sum = out_sum_reg;
    assign res.last        = out_last_reg;
endmodule

>>> hw/rtl/imm_checker.sv
// Port-level checks for the integer matrix multiplier, bound to the top level.
module imm_checker #(
    parameter int MAX_DIM = 8
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cmd_valid,
    input logic                               cmd_ready,
    input logic [imm_pkg::OP_W-1:0]           cmd_op,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic [imm_pkg::IDX_W-1:0]          res_out_row,
    input logic [imm_pkg::IDX_W-1:0]          res_out_col,
    input logic signed [imm_pkg::SUM_W-1:0]   res_product_sum,
    input logic                               res_last
);
    import imm_pkg::*;

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_row)
            && $stable(res_out_col) && $stable(res_product_sum) && $stable(res_last))
    else $error("result beat changed while stalled");

    // A multiply beat holds off further commands while the product is walked.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_op == OP_MULTIPLY |=> !cmd_ready)
    else $error("command accepted right after a multiply");

    // Emitted indexes stay inside the matrix bounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (int'(res_out_row) < MAX_DIM) && (int'(res_out_col) < MAX_DIM))
    else $error("result index out of range");
endmodule

bind integer_matrix_multiply imm_checker #(.MAX_DIM(MAX_DIM)) u_imm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_op          (cmd.op),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_out_row     (res.out_row),
    .res_out_col     (res.out_col),
    .res_product_sum (res.product_sum),
    .res_last        (res.last)
);
